// ===== hw/rtl/fnov_pkg.sv =====
// Shared constants and types for the fact novelty scorer.
package fnov_pkg;

  localparam int MAX_VARIABLES_DEF  = 64;
  localparam int MAX_DOMAIN_DEF     = 16;
  localparam int HEURISTIC_BITS_DEF = 16;

  localparam int VAR_W   = 6;
  localparam int VAL_W   = 4;
  localparam int HIN_W   = 16;
  localparam int NV_W    = 7;
  localparam int COUNT_W = 7;
  localparam int SCORE_W = 8;

  localparam logic [NV_W-1:0]    NUM_VARIABLES_RST = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 7'd127;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } fnov_state_t;

endpackage

// ===== hw/rtl/fact_novelty_scorer.sv =====
// Top level of the fact novelty scorer: best-value table, counters and scoring.
//
// Facts of a state are issued one word per cycle with start while busy is low; one fact can
// be taken every clock cycle. Each fact does one read-modify-write of the best-value table:
// the read is issued when the fact is taken and the write-back happens in the next cycle, with
// the last write forwarded so that back-to-back facts on the same entry see fresh data. The
// result of a state is on out_valid for one cycle, registered from the stage 1 copy of its last
// fact; it cannot be held off. After reset the block keeps busy high while it sweeps all
// MAX_VARIABLES * MAX_DOMAIN entries (1024 by default) of the table to unset; configuration
// writes are taken during that time.
module fact_novelty_scorer #(
  parameter int MAX_VARIABLES  = fnov_pkg::MAX_VARIABLES_DEF,
  parameter int MAX_DOMAIN     = fnov_pkg::MAX_DOMAIN_DEF,
  parameter int HEURISTIC_BITS = fnov_pkg::HEURISTIC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fnov_pkg::NV_W-1:0]    cfg_wdata,
  input  logic                         start,
  output logic                         busy,
  input  logic [fnov_pkg::VAR_W-1:0]   in_fact_variable,
  input  logic [fnov_pkg::VAL_W-1:0]   in_fact_value,
  input  logic [fnov_pkg::HIN_W-1:0]   in_heuristic_value,
  input  logic                         in_heuristic_infinite,
  input  logic                         in_last_fact,
  output logic                         out_valid,
  output logic [fnov_pkg::SCORE_W-1:0] out_novelty_score,
  output logic                         out_unsolvable
);

  localparam int DEPTH   = MAX_VARIABLES * MAX_DOMAIN;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ENTRY_W = HEURISTIC_BITS + 1;
  localparam int CW      = fnov_pkg::COUNT_W;
  localparam int SW      = fnov_pkg::SCORE_W;

  fnov_pkg::fnov_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [fnov_pkg::NV_W-1:0] num_vars_r;

  // Stage 1: fact whose table entry is being read.
  logic                      s1_valid_r;
  logic [ADDR_W-1:0]         s1_addr_r;
  logic                      s1_inrange_r;
  logic [HEURISTIC_BITS-1:0] s1_heur_r;
  logic                      s1_inf_r;
  logic                      s1_last_r;

  logic                      fwd_valid_r;
  logic [ADDR_W-1:0]         fwd_addr_r;
  logic [ENTRY_W-1:0]        fwd_data_r;

  logic [CW-1:0] better_r, better_nxt;
  logic [CW-1:0] worse_r, worse_nxt;
  logic          inf_seen_r, inf_seen_nxt;

  logic          out_valid_r;
  logic [SW-1:0] out_score_r, score_nxt;
  logic          out_dead_r;

  logic              accept;
  logic [31:0]       addr_full;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic [ENTRY_W-1:0]        ram_rdata;
  logic [ENTRY_W-1:0]        cur_entry;
  logic                      cur_set;
  logic [HEURISTIC_BITS-1:0] cur_val;
  logic                      upd, is_better, is_worse;

  assign accept    = start && !busy;
  assign addr_full = 32'(in_fact_variable) * 32'(MAX_DOMAIN) + 32'(in_fact_value);
  assign in_range  = (32'(in_fact_variable) < 32'(MAX_VARIABLES)) &&
                     (32'(in_fact_value) < 32'(MAX_DOMAIN));
  assign in_addr   = addr_full[ADDR_W-1:0];

  // Sequencer: table clearing sweep after reset, then normal operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fnov_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    busy        = 1'b0;
    case (state_r)
      fnov_pkg::ST_CLEAR: begin
        busy        = 1'b1;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt   = fnov_pkg::ST_RUN;
          clr_cnt_nxt = '0;
        end
      end
      fnov_pkg::ST_RUN: begin
        busy = 1'b0;
      end
      default: begin
        state_nxt = fnov_pkg::ST_CLEAR;
        busy      = 1'b1;
      end
    endcase
  end

  // The entry written in the previous cycle was not yet visible to the read.
  assign cur_entry = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rdata;
  assign cur_set   = cur_entry[ENTRY_W-1];
  assign cur_val   = cur_entry[HEURISTIC_BITS-1:0];

  assign upd       = s1_valid_r && !s1_inf_r && s1_inrange_r;
  assign is_better = upd && (!cur_set || (cur_val > s1_heur_r));
  assign is_worse  = upd && cur_set && (cur_val < s1_heur_r);

  always_comb begin
    if (state_r == fnov_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = is_better;
      ram_waddr = s1_addr_r;
      ram_wdata = {1'b1, s1_heur_r};
    end
  end

  fnov_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Counters and score of the state in progress.
  always_comb begin
    better_nxt   = better_r;
    worse_nxt    = worse_r;
    inf_seen_nxt = inf_seen_r || (s1_valid_r && s1_inf_r);
    if (is_better && (better_r != fnov_pkg::COUNT_MAX)) begin
      better_nxt = better_r + CW'(1);
    end
    if (is_worse && (worse_r != fnov_pkg::COUNT_MAX)) begin
      worse_nxt = worse_r + CW'(1);
    end
    if (inf_seen_nxt) begin
      score_nxt = '0;
    end else if (better_nxt != '0) begin
      score_nxt = (num_vars_r > better_nxt) ? SW'(num_vars_r - better_nxt) : '0;
    end else begin
      score_nxt = SW'(num_vars_r) + SW'(worse_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r  <= fnov_pkg::NUM_VARIABLES_RST;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      better_r    <= '0;
      worse_r     <= '0;
      inf_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_vars_r <= cfg_wdata;
      end
      s1_valid_r  <= accept;
      fwd_valid_r <= (state_r == fnov_pkg::ST_RUN) && is_better;
      out_valid_r <= s1_valid_r && s1_last_r;
      if (s1_valid_r && s1_last_r) begin
        better_r   <= '0;
        worse_r    <= '0;
        inf_seen_r <= 1'b0;
      end else begin
        better_r   <= better_nxt;
        worse_r    <= worse_nxt;
        inf_seen_r <= inf_seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r    <= in_addr;
    s1_inrange_r <= in_range;
    s1_heur_r    <= HEURISTIC_BITS'(in_heuristic_value);
    s1_inf_r     <= in_heuristic_infinite;
    s1_last_r    <= in_last_fact;
    fwd_addr_r   <= s1_addr_r;
    fwd_data_r   <= {1'b1, s1_heur_r};
    out_score_r  <= score_nxt;
    out_dead_r   <= inf_seen_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_novelty_score = out_score_r;
  assign out_unsolvable    = out_dead_r;

  // A result word only follows the last fact of a state.
  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s1_valid_r && s1_last_r))
    else $error("result word without a last fact");

  // No fact is in flight while the table is being cleared.
  a_no_fact_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fnov_pkg::ST_CLEAR) |-> !s1_valid_r)
    else $error("fact taken during table clear");

  // A dead-end result carries a zero score.
  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dead_r) |-> (out_score_r == '0))
    else $error("dead-end result with nonzero score");

endmodule

// ===== hw/rtl/fnov_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fnov_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/sv/tb_fact_novelty_scorer.sv =====
// Self-checking testbench for the fact novelty scorer: queued stimulus, predictor and checker.
`timescale 1ns / 1ps

module tb_fact_novelty_scorer;

  localparam int TABLE_SLOTS = fnov_pkg::MAX_VARIABLES_DEF * fnov_pkg::MAX_DOMAIN_DEF;
  localparam int STALL_LIMIT = 4096;

  typedef struct {
    logic [fnov_pkg::VAR_W-1:0] vix;
    logic [fnov_pkg::VAL_W-1:0] vval;
    logic [fnov_pkg::HIN_W-1:0] heur;
    logic                       inf;
    logic                       last;
  } fact_t;

  typedef struct {
    logic [fnov_pkg::SCORE_W-1:0] score;
    logic                         dead;
  } score_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [fnov_pkg::NV_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [fnov_pkg::VAR_W-1:0] in_fact_variable = '0;
  logic [fnov_pkg::VAL_W-1:0] in_fact_value = '0;
  logic [fnov_pkg::HIN_W-1:0] in_heuristic_value = '0;
  logic in_heuristic_infinite = 1'b0;
  logic in_last_fact = 1'b0;
  logic out_valid;
  logic [fnov_pkg::SCORE_W-1:0] out_novelty_score;
  logic out_unsolvable;

  // Predictor state: lowest heuristic per fact and the counts of the state in flight.
  logic [fnov_pkg::HIN_W-1:0] best_h [TABLE_SLOTS] = '{default: '0};
  logic best_set [TABLE_SLOTS] = '{default: 1'b0};
  logic [fnov_pkg::COUNT_W-1:0] n_better = '0;
  logic [fnov_pkg::COUNT_W-1:0] n_worse = '0;
  logic saw_infinite = 1'b0;
  logic [fnov_pkg::NV_W-1:0] nv_model = fnov_pkg::NUM_VARIABLES_RST;

  fact_t fact_q[$];
  score_t score_q[$];
  fact_t cur_fact;
  int n_queued = 0;
  int n_sent = 0;
  int n_errors = 0;
  int gap_left = 0;
  int stall_cycles = 0;
  bit quiet_tail = 1'b0;
  int h_level = 50000;
  int val_span = 15;

  fact_novelty_scorer uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .in_fact_variable     (in_fact_variable),
    .in_fact_value        (in_fact_value),
    .in_heuristic_value   (in_heuristic_value),
    .in_heuristic_infinite(in_heuristic_infinite),
    .in_last_fact         (in_last_fact),
    .out_valid            (out_valid),
    .out_novelty_score    (out_novelty_score),
    .out_unsolvable       (out_unsolvable)
  );

  always #5 clk = ~clk;

  function automatic void track_fact(fact_t f);
    int unsigned slot;
    int unsigned score;
    score_t exp_r;
    if (f.inf) begin
      saw_infinite = 1'b1;
    end else if (f.vix < fnov_pkg::MAX_VARIABLES_DEF && f.vval < fnov_pkg::MAX_DOMAIN_DEF) begin
      slot = f.vix * fnov_pkg::MAX_DOMAIN_DEF + f.vval;
      if (!best_set[slot] || best_h[slot] > f.heur) begin
        best_set[slot] = 1'b1;
        best_h[slot] = f.heur;
        if (n_better != fnov_pkg::COUNT_MAX) n_better = n_better + 1'b1;
      end else if (best_h[slot] < f.heur) begin
        if (n_worse != fnov_pkg::COUNT_MAX) n_worse = n_worse + 1'b1;
      end
    end
    if (f.last) begin
      if (saw_infinite) begin
        score = 0;
      end else if (n_better != 0) begin
        score = (nv_model > n_better) ? nv_model - n_better : 0;
      end else begin
        score = nv_model + n_worse;
      end
      exp_r.score = score[fnov_pkg::SCORE_W-1:0];
      exp_r.dead = saw_infinite;
      score_q.push_back(exp_r);
      n_better = '0;
      n_worse = '0;
      saw_infinite = 1'b0;
    end
  endfunction

  function automatic void push_fact(int vix, int vval, int heur, bit inf, bit last);
    fact_t f;
    f.vix = vix[fnov_pkg::VAR_W-1:0];
    f.vval = vval[fnov_pkg::VAL_W-1:0];
    f.heur = heur[fnov_pkg::HIN_W-1:0];
    f.inf = inf;
    f.last = last;
    fact_q.push_back(f);
    n_queued++;
  endfunction

  // Heuristic values drift downward so that later states beat older entries, with jitter
  // above the level to produce worse facts and occasional extremes.
  function automatic int next_heur();
    int pick;
    int h;
    pick = $urandom_range(0, 99);
    if (pick < 4) h = 0;
    else if (pick < 8) h = 65535;
    else if (pick < 20) h = $urandom_range(0, 65535);
    else h = h_level + $urandom_range(0, 24);
    if (h_level > 100) h_level -= $urandom_range(0, 6);
    return h;
  endfunction

  // A well-formed state: every variable exactly once, in shuffled order.
  function automatic void queue_proper_state(bit dead_mix);
    int order[];
    int tmp;
    int j;
    int h;
    int inf_at;
    order = new[nv_model];
    foreach (order[i]) order[i] = i;
    for (int i = nv_model - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    h = next_heur();
    inf_at = $urandom_range(0, nv_model - 1);
    foreach (order[i]) begin
      push_fact(order[i], $urandom_range(0, val_span), h,
                dead_mix && (i == inf_at || $urandom_range(0, 3) == 0),
                i == nv_model - 1);
    end
  endfunction

  // Malformed state: random variables, repeats, stray infinite flags, sometimes no last fact.
  function automatic void queue_broken_state();
    int len;
    int h;
    len = $urandom_range(1, nv_model + 2);
    h = next_heur();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) h = next_heur();
      push_fact($urandom_range(0, 63), $urandom_range(0, 15), h, $urandom_range(0, 7) == 0,
                i == len - 1 && $urandom_range(0, 9) != 0);
    end
  endfunction

  // Pins one entry at zero, then repeats it at the top value so the worse count saturates.
  function automatic void queue_flood();
    int vix;
    int vval;
    vix = $urandom_range(0, 63);
    vval = $urandom_range(0, 15);
    push_fact(vix, vval, 0, 1'b0, 1'b1);
    for (int i = 0; i < 135; i++) push_fact(vix, vval, 65535, 1'b0, i == 134);
  endfunction

  function automatic void queue_phase(int target);
    int first;
    int pick;
    first = n_queued;
    val_span = ($urandom_range(0, 1) == 0) ? 15 : $urandom_range(1, 4);
    while (n_queued - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) queue_flood();
      else if (pick < 17) queue_broken_state();
      else if (pick < 27) queue_proper_state(1'b1);
      else queue_proper_state(1'b0);
    end
    queue_proper_state(1'b0);
  endfunction

  task automatic drain();
    while (n_sent != n_queued || score_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_num_vars(input logic [fnov_pkg::NV_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    nv_model = v;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        track_fact(cur_fact);
        n_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (fact_q.size() != 0 && !quiet_tail && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 2);
          start <= 1'b0;
        end else if (fact_q.size() != 0) begin
          cur_fact = fact_q.pop_front();
          in_fact_variable <= cur_fact.vix;
          in_fact_value <= cur_fact.vval;
          in_heuristic_value <= cur_fact.heur;
          in_heuristic_infinite <= cur_fact.inf;
          in_last_fact <= cur_fact.last;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    score_t exp_r;
    if (rst_n && out_valid) begin
      if (score_q.size() == 0) begin
        $display("%0t: unexpected word, expected none got score %0d unsolvable %0b", $time,
                 out_novelty_score, out_unsolvable);
        n_errors++;
      end else begin
        exp_r = score_q.pop_front();
        if (out_novelty_score !== exp_r.score) begin
          $display("%0t: novelty_score expected %0d got %0d", $time, exp_r.score,
                   out_novelty_score);
          n_errors++;
        end
        if (out_unsolvable !== exp_r.dead) begin
          $display("%0t: unsolvable expected %0b got %0b", $time, exp_r.dead, out_unsolvable);
          n_errors++;
        end
      end
    end
  end

  // Ends the run if neither a fact nor a result moves for too long; covers the clear sweep.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("fact_novelty_scorer verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_num_vars(7'd4);

    // Fresh entries plus a repeated variable: more better facts than variables.
    push_fact(0, 0, 100, 0, 0);
    push_fact(1, 15, 100, 0, 0);
    push_fact(2, 5, 100, 0, 0);
    push_fact(3, 0, 100, 0, 0);
    push_fact(3, 9, 100, 0, 1);
    // Same facts at the top value: all worse.
    push_fact(0, 0, 65535, 0, 0);
    push_fact(1, 15, 65535, 0, 0);
    push_fact(2, 5, 65535, 0, 0);
    push_fact(3, 0, 65535, 0, 1);
    // Equal values count neither way.
    push_fact(2, 5, 100, 0, 0);
    push_fact(0, 0, 100, 0, 0);
    push_fact(3, 0, 100, 0, 0);
    push_fact(1, 15, 100, 0, 1);
    // One new fact among worse ones.
    push_fact(0, 1, 150, 0, 0);
    push_fact(1, 15, 150, 0, 0);
    push_fact(2, 5, 150, 0, 0);
    push_fact(3, 0, 150, 0, 1);
    // Mixed flags: a dead end whose finite facts still update the table.
    push_fact(0, 2, 0, 0, 0);
    push_fact(1, 3, 0, 1, 0);
    push_fact(2, 7, 0, 0, 0);
    push_fact(3, 8, 0, 0, 1);
    // Single infinite fact that is also the last.
    push_fact(5, 5, 0, 1, 1);
    drain();

    write_num_vars(7'd1);
    queue_phase(120);
    drain();
    write_num_vars(7'd63);
    queue_phase(160);
    drain();
    write_num_vars(7'($urandom_range(2, 62)));
    queue_phase(200);
    drain();
    write_num_vars(7'd64);
    queue_phase(160);
    drain();
    write_num_vars(7'd7);
    quiet_tail = 1'b1;
    queue_phase(160);
    drain();

    if (n_errors == 0) begin
      $display("fact_novelty_scorer verification clean");
    end else begin
      $display("fact_novelty_scorer verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fnov_pkg.sv
hw/rtl/fnov_ram.sv
hw/rtl/fact_novelty_scorer.sv
tb/sv/tb_fact_novelty_scorer.sv
